// ===== src/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256/224 package
// Shared types, constants and round functions for the hash engine.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int WordW = 32;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_BLOCK,
    ST_PAD_A,
    ST_PAD_B,
    ST_EMIT
  } sha_state_t;

  // Commands from the controller to the datapath, and status back.
  typedef struct packed {
    logic       take_word;
    logic       start_block;
    logic       round_step;
    logic       finish_block;
    logic       pad_fill;
    logic       pad_len;
    logic       restart;
  } sha_cmd_t;

  typedef struct packed {
    logic       block_full;
    logic       last_round;
    logic       fill_ge56;
  } sha_stat_t;

  localparam logic [31:0] IV256 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  localparam logic [31:0] IV224 [8] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};
  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

// ===== src/sha_ctrl.sv =====
// ----------------------------------------------------------------------------
// SHA controller
// Sequences word intake, the 64 rounds of each block, padding and output.
// ----------------------------------------------------------------------------
module sha_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               in_fire,
  input  logic               in_final,
  input  logic               out_fire,
  input  logic               out_last,
  input  sha_pkg::sha_stat_t stat,
  output sha_pkg::sha_cmd_t  cmd,
  output logic               in_ready,
  output logic               emitting
);
  import sha_pkg::*;

  sha_state_t state, state_next;
  logic       pend_final, pend_final_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_COLLECT;
      pend_final <= 1'b0;
    end else begin
      state      <= state_next;
      pend_final <= pend_final_next;
    end
  end

  // pend_final remembers that a block compressed mid-word was on a final word.
  always_comb begin
    state_next      = state;
    pend_final_next = pend_final;
    unique case (state)
      ST_COLLECT: begin
        if (in_fire) begin
          pend_final_next = in_final;
          if (stat.block_full) state_next = ST_BLOCK;
          else if (in_final)   state_next = ST_PAD_A;
        end
      end
      ST_BLOCK: begin
        if (stat.last_round) state_next = pend_final ? ST_PAD_A : ST_COLLECT;
      end
      ST_PAD_A: begin
        state_next = ST_PAD_B;
      end
      ST_PAD_B: begin
        if (stat.last_round) begin
          // A second block is needed only when the length did not fit.
          if (pend_final && stat.fill_ge56) begin
            pend_final_next = 1'b0;
            state_next      = ST_PAD_A;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_fire && out_last) state_next = ST_COLLECT;
      end
      default: state_next = ST_COLLECT;
    endcase
    if (cfg_we) begin
      state_next      = ST_COLLECT;
      pend_final_next = 1'b0;
    end
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    emitting = 1'b0;
    unique case (state)
      ST_COLLECT: begin
        in_ready      = 1'b1;
        cmd.take_word = in_fire;
        cmd.start_block = in_fire && stat.block_full;
      end
      ST_BLOCK: begin
        cmd.round_step   = 1'b1;
        cmd.finish_block = stat.last_round;
      end
      ST_PAD_A: begin
        // First pass lays down the marker byte; a second pass (after an
        // overflow block) only writes the length into a cleared block.
        cmd.pad_fill    = pend_final;
        cmd.pad_len     = 1'b1;
        cmd.start_block = 1'b1;
      end
      ST_PAD_B: begin
        cmd.round_step   = 1'b1;
        cmd.finish_block = stat.last_round;
      end
      ST_EMIT: begin
        emitting    = 1'b1;
        cmd.restart = out_fire && out_last;
      end
      default: ;
    endcase
    if (cfg_we) cmd.restart = 1'b1;
  end

endmodule

// ===== src/sha_dp.sv =====
// ----------------------------------------------------------------------------
// SHA datapath
// Block buffer, message schedule, round unit, chaining value and counters.
// ----------------------------------------------------------------------------
module sha_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               mode,
  input  sha_pkg::sha_cmd_t  cmd,
  input  logic [31:0]        message_word,
  input  logic [2:0]         byte_count,
  input  logic               final_word,
  input  logic [2:0]         out_idx,
  output logic [31:0]        digest_word,
  output sha_pkg::sha_stat_t stat
);
  import sha_pkg::*;

  logic [31:0] chain [8];
  logic [31:0] wv [8];
  logic [31:0] sched [16];
  logic [5:0]  fill;
  logic [63:0] msg_bits;
  logic [5:0]  round;
  logic        pad_second;

  logic [2:0]  nb;
  logic [6:0]  fill_sum;
  logic [31:0] merged_lo;
  logic [31:0] merged_hi;
  logic [31:0] w_new;
  logic [31:0] t1, t2;

  // Bytes taken from this word; a non-final word always counts four.
  always_comb begin
    if (!final_word)          nb = 3'd4;
    else if (byte_count > 3'd4) nb = 3'd4;
    else                      nb = byte_count;
  end

  assign fill_sum = {1'b0, fill} + {4'b0, nb};

  // Place nb leading bytes at byte position fill, maybe straddling two words.
  always_comb begin
    logic [63:0] win;
    logic [63:0] msk;
    logic [63:0] bytes;
    logic [63:0] bmask;
    win   = {sched[fill[5:2]], sched[fill[5:2] + 4'd1]};
    bytes = {message_word, 32'h0} >> ({3'b0, fill[1:0]} * 6'd8);
    case (nb)
      3'd0:    bmask = 64'h0;
      3'd1:    bmask = 64'hff00_0000_0000_0000;
      3'd2:    bmask = 64'hffff_0000_0000_0000;
      3'd3:    bmask = 64'hffff_ff00_0000_0000;
      default: bmask = 64'hffff_ffff_0000_0000;
    endcase
    msk = bmask >> ({3'b0, fill[1:0]} * 6'd8);
    win = (win & ~msk) | (bytes & msk);
    merged_hi = win[63:32];
    merged_lo = win[31:0];
  end

  assign w_new = ssig1(sched[14]) + sched[9] + ssig0(sched[1]) + sched[0];

  assign t1 = wv[7] + bsig1(wv[4]) + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6]))
            + ROUND_K[round] + sched[0];
  assign t2 = bsig0(wv[0]) + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));

  assign stat.block_full = fill_sum[6];
  assign stat.last_round = (round == 6'd63);
  assign stat.fill_ge56  = (fill >= 6'd56);

  assign digest_word = chain[out_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      msg_bits   <= '0;
      round      <= '0;
      pad_second <= 1'b0;
      for (int i = 0; i < 8; i++) chain[i] <= IV256[i];
    end else begin
      if (cmd.take_word) begin
        sched[fill[5:2]] <= merged_hi;
        if (fill[1:0] != 2'd0) sched[fill[5:2] + 4'd1] <= merged_lo;
        fill     <= fill_sum[5:0];
        msg_bits <= msg_bits + {58'b0, nb, 3'b0};
      end
      if (cmd.pad_len) begin
        for (int i = 0; i < 16; i++) begin
          logic [5:0] b;
          b = 6'(i * 4);
          if (cmd.pad_fill) begin
            if ({2'b0, fill[5:2]} == 6'(i)) begin
              case (fill[1:0])
                2'd0: sched[i] <= 32'h8000_0000;
                2'd1: sched[i] <= {sched[i][31:24], 24'h80_0000};
                2'd2: sched[i] <= {sched[i][31:16], 16'h8000};
                default: sched[i] <= {sched[i][31:8], 8'h80};
              endcase
            end else if (b > fill) begin
              sched[i] <= '0;
            end
          end else begin
            sched[i] <= '0;
          end
        end
        // The length goes in now unless it no longer fits behind the data.
        if (!cmd.pad_fill || fill < 6'd56) begin
          sched[14] <= msg_bits[63:32];
          sched[15] <= msg_bits[31:0];
        end
        pad_second <= cmd.pad_fill && fill >= 6'd56;
      end
      if (cmd.start_block) begin
        round <= '0;
        for (int i = 0; i < 8; i++) wv[i] <= chain[i];
      end
      if (cmd.round_step) begin
        round <= round + 6'd1;
        for (int i = 0; i < 15; i++) sched[i] <= sched[i + 1];
        sched[15] <= w_new;
        wv[7] <= wv[6]; wv[6] <= wv[5]; wv[5] <= wv[4]; wv[4] <= wv[3] + t1;
        wv[3] <= wv[2]; wv[2] <= wv[1]; wv[1] <= wv[0]; wv[0] <= t1 + t2;
        if (cmd.finish_block) begin
          chain[0] <= chain[0] + t1 + t2;
          chain[1] <= chain[1] + wv[0];
          chain[2] <= chain[2] + wv[1];
          chain[3] <= chain[3] + wv[2];
          chain[4] <= chain[4] + wv[3] + t1;
          chain[5] <= chain[5] + wv[4];
          chain[6] <= chain[6] + wv[5];
          chain[7] <= chain[7] + wv[6];
          // A full data block leaves an empty buffer behind it.
          if (!pad_second) fill <= '0;
        end
      end
      if (cmd.restart) begin
        fill       <= '0;
        msg_bits   <= '0;
        pad_second <= 1'b0;
        for (int i = 0; i < 8; i++) chain[i] <= mode ? IV224[i] : IV256[i];
      end
    end
  end

endmodule

// ===== src/sha256_sha224_hash_engine_core.sv =====
// ----------------------------------------------------------------------------
// SHA-256/224 hash engine
// Streams message words in and returns the eight digest words per message.
// ----------------------------------------------------------------------------
// Words are accepted while collecting; every sixteenth word fills a block, and
// input is then held off while the single shared round unit compresses it.
// A final word adds one or two padding blocks, and the eight digest words
// then leave one per accepted output word.
// Writing hash_mode restarts the message with the chosen initial values.
module sha256_sha224_hash_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,      // hash_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // message_word, byte_count, zero fill
  input  logic        s_axis_tlast,   // final_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // digest_word, word_index, zero fill
  output logic        m_axis_tlast    // digest_done
);
  import sha_pkg::*;

  sha_cmd_t  cmd;
  sha_stat_t stat;
  logic      mode;
  logic      in_fire, out_fire, emitting;
  logic [2:0] out_idx;
  logic [31:0] dword;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= 1'b0;
      out_idx <= '0;
    end else begin
      if (cfg_we) mode <= cfg_wdata;
      if (cfg_we)        out_idx <= '0;
      else if (out_fire) out_idx <= out_idx + 3'd1;
    end
  end

  sha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .in_fire  (in_fire),
    .in_final (s_axis_tlast),
    .out_fire (out_fire),
    .out_last (m_axis_tlast),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (s_axis_tready),
    .emitting (emitting)
  );

  sha_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .mode         (cfg_we ? cfg_wdata : mode),
    .cmd          (cmd),
    .message_word (s_axis_tdata[31:0]),
    .byte_count   (s_axis_tdata[34:32]),
    .final_word   (s_axis_tlast),
    .out_idx      (out_idx),
    .digest_word  (dword),
    .stat         (stat)
  );

  assign m_axis_tvalid = emitting;
  assign m_axis_tdata  = {5'b0, out_idx, dword};
  assign m_axis_tlast  = (out_idx == 3'd7);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input accepted while digest is being sent");

  a_idx_wrap: assert property (@(posedge clk) disable iff (rst)
    (out_fire && m_axis_tlast && !cfg_we) |=> (out_idx == 3'd0))
    else $error("digest index did not wrap");

  a_idx_zero_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> out_idx == 3'd0)
    else $error("digest index not reset while collecting");

endmodule
